// File: sv/bfq_pkg.sv
// Shared constants, probe tables and types for the Bloom filter query core.
package bfq_pkg;

    localparam int KEY_W      = 32;
    localparam int IDX_W      = 6;
    localparam int BYTE_W     = 8;
    localparam int T_W        = KEY_W + 3;
    localparam int RECIP_W    = 34;
    localparam int NUM_PROBES = 4;

    localparam int FILTER_BYTES_DEF = 38;

    localparam logic [KEY_W:0] HASH_PRIME = 33'd4294967291;
    localparam int             FOLD_K     = 5;

    localparam int PROBE_MUL [NUM_PROBES] = '{1, 3, 5, 7};
    localparam int PROBE_ADD [NUM_PROBES] = '{2, 4, 6, 8};

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [BYTE_W-1:0] data;
    } t_store_wr;

endpackage

// File: sv/bfq_hash_fold.sv
// Four affine key hashes reduced modulo the hash prime.
module bfq_hash_fold (
    input  logic [bfq_pkg::KEY_W-1:0] i_key,
    output logic [bfq_pkg::KEY_W-1:0] o_x [bfq_pkg::NUM_PROBES]
);
    import bfq_pkg::*;

    logic [T_W-1:0]   t [NUM_PROBES];
    logic [KEY_W:0]   u [NUM_PROBES];

    // 2^32 is congruent to FOLD_K, so fold the top bits back in once
    always_comb begin
        for (int p = 0; p < NUM_PROBES; p++) begin
            t[p] = T_W'(i_key) * T_W'(PROBE_MUL[p]) + T_W'(PROBE_ADD[p]);
            u[p] = (KEY_W + 1)'(t[p][KEY_W-1:0])
                 + (KEY_W + 1)'(t[p][T_W-1:KEY_W]) * (KEY_W + 1)'(FOLD_K);
            o_x[p] = (u[p] >= HASH_PRIME) ? KEY_W'(u[p] - HASH_PRIME)
                                          : u[p][KEY_W-1:0];
        end
    end

endmodule

// File: sv/bfq_store.sv
// Filter byte store: two mirrored banks, two read ports each, valid flags.
module bfq_store #(
    parameter  int FILTER_BYTES = bfq_pkg::FILTER_BYTES_DEF,
    localparam int ADDR_W       = (FILTER_BYTES > 1) ? $clog2(FILTER_BYTES) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bfq_pkg::t_store_wr         i_wr,
    input  logic                       i_rd_en,
    input  logic [ADDR_W-1:0]          i_rd_addr [bfq_pkg::NUM_PROBES],
    output logic [bfq_pkg::BYTE_W-1:0] o_rd_byte [bfq_pkg::NUM_PROBES]
);
    import bfq_pkg::*;

    logic [BYTE_W-1:0]       mem_a [FILTER_BYTES];
    logic [BYTE_W-1:0]       mem_b [FILTER_BYTES];
    logic [FILTER_BYTES-1:0] r_vld;
    logic [BYTE_W-1:0]       r_rd_byte [NUM_PROBES];
    logic [NUM_PROBES-1:0]   r_rd_vld;
    logic                    wr_hit;
    logic [ADDR_W-1:0]       wr_addr;

    assign wr_hit  = i_wr.en && (32'(i_wr.idx) < FILTER_BYTES);
    assign wr_addr = ADDR_W'(i_wr.idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wr_hit) begin
            r_vld[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_hit) begin
            mem_a[wr_addr] <= i_wr.data;
            mem_b[wr_addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_byte[0] <= mem_a[i_rd_addr[0]];
            r_rd_byte[1] <= mem_a[i_rd_addr[1]];
            r_rd_byte[2] <= mem_b[i_rd_addr[2]];
            r_rd_byte[3] <= mem_b[i_rd_addr[3]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            for (int p = 0; p < NUM_PROBES; p++) begin
                r_rd_vld[p] <= r_vld[i_rd_addr[p]];
            end
        end
    end

    // never-written bytes read as zero
    always_comb begin
        for (int p = 0; p < NUM_PROBES; p++) begin
            o_rd_byte[p] = r_rd_vld[p] ? r_rd_byte[p] : '0;
        end
    end

endmodule

// File: sv/bloom_filter_membership_query_core.sv
// Bloom filter membership query core: load/query pipeline and probe evaluation.
// Throughput: one beat per cycle while i_ready holds; stages are the input
// register, hash fold, reciprocal multiply, remainder plus store read, and the
// result register, each with its own stall.
// Loads pass down the same pipeline and write the store at the read stage.
// Reset (synchronous, active low) empties the pipeline and clears the store's
// valid flags, so every byte reads as zero at once; there is no clearing pass.
module bloom_filter_membership_query_core #(
    parameter int FILTER_BYTES = bfq_pkg::FILTER_BYTES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_func,
    input  logic [bfq_pkg::IDX_W-1:0]  i_byte_index,
    input  logic [bfq_pkg::BYTE_W-1:0] i_filter_byte,
    input  logic [bfq_pkg::KEY_W-1:0]  i_key,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_is_member
);
    import bfq_pkg::*;

    localparam int FILTER_BITS = FILTER_BYTES * BYTE_W;
    localparam int POS_W       = $clog2(FILTER_BITS);
    localparam int ADDR_W      = (FILTER_BYTES > 1) ? $clog2(FILTER_BYTES) : 1;
    localparam int SHIFT       = KEY_W + POS_W;
    localparam int Q_W         = KEY_W + 1 - POS_W;
    localparam int PROD_W      = KEY_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((64'd1 << SHIFT) / 64'(FILTER_BITS) + 64'd1);

    logic [4:0] rdy;

    // stage 0: input register
    logic              r_v0, r_func0;
    logic [IDX_W-1:0]  r_idx0;
    logic [BYTE_W-1:0] r_fbyte0;
    logic [KEY_W-1:0]  r_key0;

    // stage 1: residues modulo the prime
    logic              r_v1, r_func1;
    logic [IDX_W-1:0]  r_idx1;
    logic [BYTE_W-1:0] r_fbyte1;
    logic [KEY_W-1:0]  r_x1 [NUM_PROBES];
    logic [KEY_W-1:0]  fold_x [NUM_PROBES];

    // stage 2: quotients by the filter size
    logic              r_v2, r_func2;
    logic [IDX_W-1:0]  r_idx2;
    logic [BYTE_W-1:0] r_fbyte2;
    logic [KEY_W-1:0]  r_x2 [NUM_PROBES];
    logic [Q_W-1:0]    r_q2 [NUM_PROBES];
    logic [PROD_W-1:0] prod [NUM_PROBES];

    // remainder and store access
    logic [KEY_W-1:0]  qm      [NUM_PROBES];
    logic [KEY_W-1:0]  rem_raw [NUM_PROBES];
    logic [POS_W-1:0]  pos     [NUM_PROBES];
    logic [ADDR_W-1:0] rd_addr [NUM_PROBES];
    logic [BYTE_W-1:0] rd_byte [NUM_PROBES];
    t_store_wr         store_wr;

    // stage 3: probe positions, store bytes alongside
    logic              r_v3, r_func3;
    logic [POS_W-1:0]  r_pos3 [NUM_PROBES];
    logic [NUM_PROBES-1:0] probe_bit;
    logic              member;

    // stage 4: result register
    logic              r_v4, r_member4;

    assign rdy[4]  = !r_v4 || i_ready;
    assign rdy[3]  = !r_v3 || rdy[4];
    assign rdy[2]  = !r_v2 || rdy[3];
    assign rdy[1]  = !r_v1 || rdy[2];
    assign rdy[0]  = !r_v0 || rdy[1];
    assign o_ready = rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy[0]) r_v0 <= i_valid;
            if (rdy[1]) r_v1 <= r_v0;
            if (rdy[2]) r_v2 <= r_v1;
            if (rdy[3]) r_v3 <= r_v2;
            if (rdy[4]) r_v4 <= r_v3 && (r_func3 == FUNC_QUERY);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_func0  <= i_func;
            r_idx0   <= i_byte_index;
            r_fbyte0 <= i_filter_byte;
            r_key0   <= i_key;
        end
    end

    bfq_hash_fold u_fold (
        .i_key (r_key0),
        .o_x   (fold_x)
    );

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r_func1  <= r_func0;
            r_idx1   <= r_idx0;
            r_fbyte1 <= r_fbyte0;
            for (int p = 0; p < NUM_PROBES; p++) begin
                r_x1[p] <= fold_x[p];
            end
        end
    end

    always_comb begin
        for (int p = 0; p < NUM_PROBES; p++) begin
            prod[p] = PROD_W'(r_x1[p]) * PROD_W'(RECIP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r_func2  <= r_func1;
            r_idx2   <= r_idx1;
            r_fbyte2 <= r_fbyte1;
            for (int p = 0; p < NUM_PROBES; p++) begin
                r_x2[p] <= r_x1[p];
                r_q2[p] <= Q_W'(prod[p] >> SHIFT);
            end
        end
    end

    always_comb begin
        for (int p = 0; p < NUM_PROBES; p++) begin
            qm[p]      = KEY_W'(KEY_W'(r_q2[p]) * KEY_W'(FILTER_BITS));
            rem_raw[p] = r_x2[p] - qm[p];
            pos[p]     = (rem_raw[p] >= KEY_W'(FILTER_BITS))
                       ? POS_W'(rem_raw[p] - KEY_W'(FILTER_BITS))
                       : POS_W'(rem_raw[p]);
            rd_addr[p] = ADDR_W'(pos[p] >> 3);
        end
    end

    assign store_wr.en   = rdy[3] && r_v2 && (r_func2 == FUNC_LOAD);
    assign store_wr.idx  = r_idx2;
    assign store_wr.data = r_fbyte2;

    bfq_store #(
        .FILTER_BYTES (FILTER_BYTES)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (store_wr),
        .i_rd_en   (rdy[3]),
        .i_rd_addr (rd_addr),
        .o_rd_byte (rd_byte)
    );

    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r_func3 <= r_func2;
            for (int p = 0; p < NUM_PROBES; p++) begin
                r_pos3[p] <= pos[p];
            end
        end
    end

    // MSB-first bit order within a byte
    always_comb begin
        for (int p = 0; p < NUM_PROBES; p++) begin
            probe_bit[p] = rd_byte[p][~r_pos3[p][2:0]];
        end
        member = !probe_bit[2] && !probe_bit[3]
              && (probe_bit[0] || r_pos3[0] == r_pos3[2] || r_pos3[0] == r_pos3[3])
              && (probe_bit[1] || r_pos3[1] == r_pos3[2] || r_pos3[1] == r_pos3[3]);
    end

    always_ff @(posedge i_clk) begin
        if (rdy[4]) begin
            r_member4 <= member;
        end
    end

    assign o_valid     = r_v4;
    assign o_is_member = r_member4;

    for (genvar g = 0; g < NUM_PROBES; g++) begin : g_chk
        a_fold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_v1 |-> ((KEY_W + 1)'(r_x1[g]) < HASH_PRIME))
            else $error("residue not below hash prime");
        a_quot_exact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_v2 |-> (rem_raw[g] < KEY_W'(FILTER_BITS)))
            else $error("reciprocal quotient off by one");
    end

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rdy[4] && r_v3 && r_func3 == FUNC_LOAD) |=> !o_valid)
        else $error("load beat produced a result");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_v3 && r_func3 == FUNC_QUERY))
        else $error("result without a query beat");

endmodule

// File: bench/bfq_query_checker.sv
// Beat monitor, membership predictor and result scoreboard for the Bloom filter query core.
`timescale 1ns / 1ps

module bfq_query_checker #(
    parameter int NBYTES = bfq_pkg::FILTER_BYTES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic                       i_func,
    input  logic [bfq_pkg::IDX_W-1:0]  i_byte_index,
    input  logic [bfq_pkg::BYTE_W-1:0] i_filter_byte,
    input  logic [bfq_pkg::KEY_W-1:0]  i_key,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic                       i_is_member,
    output int                         o_fail_count,
    output int                         o_pending
);

    localparam logic [63:0] HASH_MOD    = 64'd4294967291;
    localparam logic [63:0] FILTER_BITS = 64'(NBYTES * 8);

    logic [bfq_pkg::BYTE_W-1:0] filter_img [NBYTES];
    logic                       member_exp_q [$];
    logic                       member_exp;

    // probe n uses multiplier 2n+1 and offset 2n+2
    function automatic int unsigned hash_pos(input int unsigned n,
                                             input logic [bfq_pkg::KEY_W-1:0] k);
        logic [63:0] v;
        v = {32'd0, k} * (2 * n + 1) + (2 * n + 2);
        return int'((v % HASH_MOD) % FILTER_BITS);
    endfunction

    function automatic logic filter_bit(input int unsigned pos);
        logic [bfq_pkg::BYTE_W-1:0] mask;
        mask = 8'h80 >> (pos % 8);
        return (filter_img[pos / 8] & mask) != 0;
    endfunction

    function automatic logic query_member(input logic [bfq_pkg::KEY_W-1:0] k);
        int unsigned s0;
        int unsigned s1;
        int unsigned r0;
        int unsigned r1;
        logic        hit;
        s0  = hash_pos(0, k);
        s1  = hash_pos(1, k);
        r0  = hash_pos(2, k);
        r1  = hash_pos(3, k);
        hit = !filter_bit(r0) && !filter_bit(r1);
        if (!filter_bit(s0) && s0 != r0 && s0 != r1) hit = 1'b0;
        if (!filter_bit(s1) && s1 != r0 && s1 != r1) hit = 1'b0;
        return hit;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < NBYTES; b++) filter_img[b] = '0;
            member_exp_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (member_exp_q.size() == 0) begin
                    $error("is_member: beat with nothing expected, actual %0b", i_is_member);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    member_exp = member_exp_q.pop_front();
                    if (i_is_member !== member_exp) begin
                        $error("is_member: expected %0b, actual %0b", member_exp, i_is_member);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_func == bfq_pkg::FUNC_QUERY) begin
                    member_exp_q.push_back(query_member(i_key));
                end else if (i_byte_index < NBYTES) begin
                    filter_img[i_byte_index] = i_filter_byte;
                end
            end
        end
        o_pending = member_exp_q.size();
    end

endmodule

// File: bench/bloom_filter_membership_query_core_tb.sv
// Stimulus, clocking and verdict for the Bloom filter query core testbench.
`timescale 1ns / 1ps

module bloom_filter_membership_query_core_tb;

    localparam int          NBYTES       = bfq_pkg::FILTER_BYTES_DEF;
    localparam int          NUM_ITEMS    = 800;
    localparam int          CALM_ITEMS   = 100;
    localparam int          DRAIN_CYCLES = 12;
    localparam int unsigned LIMIT        = 300000;
    localparam logic [63:0] HASH_MOD     = 64'd4294967291;
    localparam logic [63:0] FILTER_BITS  = 64'(NBYTES * 8);

    logic                       i_clk         = 1'b0;
    logic                       i_rst_n       = 1'b0;
    logic                       i_valid       = 1'b0;
    logic                       i_func        = bfq_pkg::FUNC_LOAD;
    logic [bfq_pkg::IDX_W-1:0]  i_byte_index  = '0;
    logic [bfq_pkg::BYTE_W-1:0] i_filter_byte = '0;
    logic [bfq_pkg::KEY_W-1:0]  i_key         = '0;
    logic                       i_ready       = 1'b0;
    logic                       o_ready;
    logic                       o_valid;
    logic                       o_is_member;

    int          fail_count;
    int          pending;
    int unsigned cycle_cnt  = 0;
    int          stall_left = 0;
    int          sent       = 0;
    bit          calm       = 1'b0;

    logic [bfq_pkg::BYTE_W-1:0] img [NBYTES];
    logic [bfq_pkg::KEY_W-1:0]  known_keys [$];

    bloom_filter_membership_query_core #(
        .FILTER_BYTES(NBYTES)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_func       (i_func),
        .i_byte_index (i_byte_index),
        .i_filter_byte(i_filter_byte),
        .i_key        (i_key),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_is_member  (o_is_member)
    );

    bfq_query_checker #(
        .NBYTES(NBYTES)
    ) chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_func       (i_func),
        .i_byte_index (i_byte_index),
        .i_filter_byte(i_filter_byte),
        .i_key        (i_key),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_is_member  (o_is_member),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side back-pressure in bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            i_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 11);
        end else begin
            i_ready <= 1'b1;
        end
    end

    // bit position aimed at by probe n, used to steer loads towards a key
    function automatic int unsigned aim_pos(input int unsigned n,
                                            input logic [bfq_pkg::KEY_W-1:0] k);
        logic [63:0] v;
        v = {32'd0, k} * (2 * n + 1) + (2 * n + 2);
        return int'((v % HASH_MOD) % FILTER_BITS);
    endfunction

    task automatic send_beat(input logic f, input logic [bfq_pkg::IDX_W-1:0] idx,
                             input logic [bfq_pkg::BYTE_W-1:0] b,
                             input logic [bfq_pkg::KEY_W-1:0] k);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_func        <= f;
        i_byte_index  <= idx;
        i_filter_byte <= b;
        i_key         <= k;
        do @(posedge i_clk); while (!o_ready);
        if (!(f == bfq_pkg::FUNC_LOAD && idx >= NBYTES)) sent++;
        @(negedge i_clk);
    endtask

    task automatic load_byte(input logic [bfq_pkg::IDX_W-1:0] idx,
                             input logic [bfq_pkg::BYTE_W-1:0] b);
        if (idx < NBYTES) img[idx] = b;
        send_beat(bfq_pkg::FUNC_LOAD, idx, b, $urandom);
    endtask

    task automatic query_key(input logic [bfq_pkg::KEY_W-1:0] k);
        send_beat(bfq_pkg::FUNC_QUERY, bfq_pkg::IDX_W'($urandom),
                  bfq_pkg::BYTE_W'($urandom), k);
    endtask

    // set probes 0/1, clear 2/3, write touched bytes, maybe garble one, ask
    task automatic insert_key(input logic [bfq_pkg::KEY_W-1:0] k);
        int unsigned p [4];
        int unsigned n;
        for (n = 0; n < 4; n++) p[n] = aim_pos(n, k);
        for (n = 0; n < 2; n++) img[p[n] / 8] = img[p[n] / 8] | (8'h80 >> (p[n] % 8));
        for (n = 2; n < 4; n++) img[p[n] / 8] = img[p[n] / 8] & ~(8'h80 >> (p[n] % 8));
        for (n = 0; n < 4; n++) load_byte(bfq_pkg::IDX_W'(p[n] / 8), img[p[n] / 8]);
        if ($urandom_range(0, 4) == 0) begin
            load_byte(bfq_pkg::IDX_W'(p[$urandom_range(0, 3)] / 8), bfq_pkg::BYTE_W'($urandom));
        end
        query_key(k);
        known_keys.push_back(k);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    initial begin
        int  pick;
        bit  pressed;
        pressed = 1'b0;
        for (int b = 0; b < NBYTES; b++) img[b] = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        query_key(32'h0000_0000);
        query_key(32'd75);
        query_key(32'hFFFF_FFFF);
        query_key(32'hFFFF_FFF9);
        load_byte(6'd0, 8'hFF);
        load_byte(6'd37, 8'hFF);
        load_byte(6'd38, 8'hFF);
        load_byte(6'd63, 8'hAA);
        query_key(32'h0000_0000);
        load_byte(6'd0, 8'h28);
        query_key(32'h0000_0000);
        query_key(32'hFFFF_FFFB);
        query_key(32'hFFFF_FFFA);
        load_byte(6'd32, 8'h55);
        query_key(32'h8000_0000);
        load_byte(6'd0, 8'h00);
        load_byte(6'd37, 8'h00);
        query_key(32'd75);
        insert_key(32'hFFFF_FFFF);

        drain_results();

        while (sent < NUM_ITEMS) begin
            if (!pressed && sent >= NUM_ITEMS / 2) begin
                drain_results();
                pressed = 1'b1;
            end
            calm = (sent >= NUM_ITEMS - CALM_ITEMS);
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                insert_key($urandom);
            end else if (pick < 40) begin
                insert_key($urandom_range(0, 1000));
            end else if (pick < 55 && known_keys.size() > 0) begin
                query_key(known_keys[$urandom_range(0, known_keys.size() - 1)]);
            end else if (pick < 65) begin
                query_key($urandom);
            end else if (pick < 75) begin
                query_key($urandom_range(0, 1000));
            end else if (pick < 93) begin
                load_byte(bfq_pkg::IDX_W'($urandom_range(0, NBYTES - 1)),
                          bfq_pkg::BYTE_W'($urandom));
            end else begin
                load_byte(bfq_pkg::IDX_W'($urandom_range(NBYTES, 63)),
                          bfq_pkg::BYTE_W'($urandom));
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
